/* sv/ter_pkg.sv */
`timescale 1ns / 1ps

package ter_pkg;

  typedef logic [1:0]       cid_t;   // corner position or original corner
  typedef cid_t [3:0]       perm_t;  // position -> original corner
  typedef logic [3:0]       sym_t;   // 0..3 corner, 4..9 split point of edge 0..5
  typedef logic [3:0][3:0]  gt_t;    // gt[i][j]: corner i index above corner j
  typedef logic [2:0][2:0]  lt_t;    // lt[x][y]: diagonal x shorter than y

  typedef struct packed {
    logic [3:0]          n;
    sym_t [7:0][3:0]     sym;
  } run_t;

  typedef struct packed {
    perm_t p;
    logic  par;
  } srt_t;

  localparam logic [3:0] AllCorners = 4'hF;
  localparam logic [3:0] CA = 4'd1;
  localparam logic [3:0] CB = 4'd2;
  localparam logic [3:0] CC = 4'd4;
  localparam logic [3:0] CD = 4'd8;

  localparam cid_t PA = 2'd0;
  localparam cid_t PB = 2'd1;
  localparam cid_t PC = 2'd2;
  localparam cid_t PD = 2'd3;

  localparam sym_t SymSplit = 4'd4;
  localparam sym_t SymLast  = 4'd9;

  // edges ab ac ad bc bd cd, index 0 rightmost (EdgeMask, EdgeLo and EdgeHi all use this order)
  localparam logic [5:0][3:0] EdgeMask = {4'd12, 4'd10, 4'd6, 4'd9, 4'd5, 4'd3};
  localparam logic [5:0][1:0] EdgeLo   = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [5:0][1:0] EdgeHi   = {2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};

  function automatic logic [2:0] cidx(logic [3:0] c);
    case (c)
      CA:      return 3'd0;
      CB:      return 3'd1;
      CC:      return 3'd2;
      CD:      return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [3:0] lowb(logic [3:0] e);
    return e & (~e + 4'd1);
  endfunction

  function automatic logic [3:0] trk(logic [3:0] c1, logic [3:0] c2, logic [3:0] x);
    if (x == c1) return c2;
    else if (x == c2) return c1;
    return x;
  endfunction

  function automatic perm_t pswap(perm_t p, logic [3:0] c1, logic [3:0] c2);
    logic [2:0] i;
    logic [2:0] j;
    cid_t       t;
    perm_t      q;
    q = p;
    i = cidx(c1);
    j = cidx(c2);
    if (c1 != c2 && !i[2] && !j[2]) begin
      t = q[i[1:0]];
      q[i[1:0]] = q[j[1:0]];
      q[j[1:0]] = t;
    end
    return q;
  endfunction

  function automatic logic [2:0] eidx(cid_t a, cid_t b);
    cid_t lo;
    cid_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ({lo, hi})
      4'b0001: return 3'd0;
      4'b0010: return 3'd1;
      4'b0011: return 3'd2;
      4'b0110: return 3'd3;
      4'b0111: return 3'd4;
      4'b1011: return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  // opposite edges share one diagonal length
  function automatic logic [1:0] dg(logic [2:0] e);
    case (e)
      3'd0, 3'd5: return 2'd0;
      3'd1, 3'd4: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  function automatic sym_t tv(perm_t p, cid_t k);
    return {2'b00, p[k]};
  endfunction

  function automatic sym_t ps(perm_t p, cid_t k, cid_t l);
    return SymSplit + {1'b0, eidx(p[k], p[l])};
  endfunction

  function automatic sym_t mtv(perm_t p, logic [3:0] m);
    logic [2:0] k;
    k = cidx(m);
    return tv(p, k[1:0]);
  endfunction

  function automatic sym_t mps(perm_t p, logic [3:0] m);
    logic [2:0] k;
    logic [2:0] l;
    k = cidx(lowb(m));
    l = cidx(m ^ lowb(m));
    return ps(p, k[1:0], l[1:0]);
  endfunction

  function automatic logic gtp(gt_t gt, perm_t p, cid_t k, cid_t l);
    return gt[p[k]][p[l]];
  endfunction

  function automatic logic ltd(lt_t lt, perm_t p, cid_t k1, cid_t l1, cid_t k2, cid_t l2);
    return lt[dg(eidx(p[k1], p[l1]))][dg(eidx(p[k2], p[l2]))];
  endfunction

  function automatic run_t emt(run_t r, logic f, sym_t a, sym_t b, sym_t c, sym_t d);
    run_t q;
    q = r;
    q.sym[r.n[2:0]][0] = a;
    q.sym[r.n[2:0]][1] = b;
    q.sym[r.n[2:0]][2] = f ? d : c;
    q.sym[r.n[2:0]][3] = f ? c : d;
    q.n = r.n + 4'd1;
    return q;
  endfunction

  // exchange sort of the corners, positions tracked as a permutation
  function automatic srt_t ter_sort(gt_t gt);
    srt_t s;
    cid_t t;
    s.p   = {PD, PC, PB, PA};
    s.par = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (gt[s.p[EdgeLo[k]]][s.p[EdgeHi[k]]]) begin
        t = s.p[EdgeLo[k]];
        s.p[EdgeLo[k]] = s.p[EdgeHi[k]];
        s.p[EdgeHi[k]] = t;
        s.par = ~s.par;
      end
    end
    return s;
  endfunction

  // prelude shared by the touching-pair cases: common corner to A, ends to B, C, then order B/C
  function automatic srt_t ter_touch(srt_t s_in, gt_t gt, logic [3:0] m0, logic [3:0] m1);
    srt_t       s;
    logic [3:0] cm;
    logic [3:0] p1;
    logic [3:0] p2;
    s  = s_in;
    cm = m0 & m1;
    p1 = m0 ^ cm;
    p2 = m1 ^ cm;
    p1 = trk(cm, CA, p1);
    p2 = trk(cm, CA, p2);
    if (cm != CA) s.par = ~s.par;
    s.p = pswap(s.p, cm, CA);
    p2 = trk(p1, CB, p2);
    if (p1 != CB) s.par = ~s.par;
    s.p = pswap(s.p, p1, CB);
    if (p2 != CC) s.par = ~s.par;
    s.p = pswap(s.p, p2, CC);
    if (gtp(gt, s.p, PB, PC)) begin
      s.par = ~s.par;
      s.p = pswap(s.p, CB, CC);
    end
    return s;
  endfunction

  // prelude of the cases keyed on one edge: its ends to A, B, then order A/B, C/D
  function automatic srt_t ter_edge(srt_t s_in, gt_t gt, logic [3:0] e);
    srt_t       s;
    logic [3:0] st;
    logic [3:0] en;
    s  = s_in;
    st = lowb(e);
    en = trk(st, CA, e ^ st);
    if (st != CA) s.par = ~s.par;
    s.p = pswap(s.p, st, CA);
    if (en != CB) s.par = ~s.par;
    s.p = pswap(s.p, en, CB);
    if (gtp(gt, s.p, PA, PB)) begin
      s.par = ~s.par;
      s.p = pswap(s.p, CA, CB);
    end
    if (gtp(gt, s.p, PC, PD)) begin
      s.par = ~s.par;
      s.p = pswap(s.p, CC, CD);
    end
    return s;
  endfunction

  function automatic run_t ter_build(srt_t s_in, logic [5:0] sv, gt_t gt, lt_t lt);
    srt_t             s;
    perm_t            p;
    logic             f;
    logic [5:0][3:0]  sl;
    logic [5:0][3:0]  nl;
    logic [2:0]       ns;
    logic [2:0]       nn;
    logic [3:0]       se;
    logic [3:0]       oe;
    logic [3:0]       s0;
    logic [3:0]       o0;
    logic [3:0]       c01;
    logic [3:0]       c02;
    logic [3:0]       c12;
    logic [3:0]       rs;
    logic [3:0]       re;
    logic [3:0]       rc;
    logic [3:0][1:0]  hits;
    logic [2:0]       fi;
    logic [2:0]       se2;
    logic             fnd;
    logic [1:0]       d1;
    logic [1:0]       d2;
    logic [1:0]       d3;
    run_t             r;
    r    = '0;
    s    = s_in;
    sl   = '0;
    nl   = '0;
    ns   = '0;
    nn   = '0;
    hits = '0;
    rc   = '0;
    fnd  = 1'b0;
    fi   = 3'd4;
    se2  = 3'd4;
    for (int i = 0; i < 6; i++) begin
      if (sv[eidx(s.p[EdgeLo[i]], s.p[EdgeHi[i]])]) begin
        sl[ns] = EdgeMask[i];
        ns = ns + 3'd1;
      end else begin
        nl[nn] = EdgeMask[i];
        nn = nn + 3'd1;
      end
    end
    c01 = sl[0] & sl[1];
    c02 = sl[0] & sl[2];
    c12 = sl[1] & sl[2];
    case (ns)
      3'd0: begin
        r = emt(r, 1'b0, 4'd0, 4'd1, 4'd2, 4'd3);
      end
      3'd1: begin
        p  = s.p;
        se = sl[0];
        oe = AllCorners ^ se;
        s0 = lowb(se);
        o0 = lowb(oe);
        r = emt(r, 1'b0, mtv(p, o0), mtv(p, oe ^ o0), mtv(p, s0), mps(p, se));
        r = emt(r, 1'b0, mtv(p, o0), mtv(p, oe ^ o0), mps(p, se), mtv(p, se ^ s0));
      end
      3'd2: begin
        if (c01 != 4'd0) begin
          s = ter_touch(s, gt, sl[0], sl[1]);
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PA), tv(p, PD), ps(p, PA, PB), ps(p, PA, PC));
          r = emt(r, f, tv(p, PD), tv(p, PB), ps(p, PA, PB), ps(p, PA, PC));
          r = emt(r, f, tv(p, PD), tv(p, PC), tv(p, PB), ps(p, PA, PC));
        end else begin
          s0 = lowb(sl[0]);
          if (s0 != CA) s.par = ~s.par;
          s.p = pswap(s.p, s0, CA);
          if ((sl[0] ^ s0) != CB) s.par = ~s.par;
          s.p = pswap(s.p, sl[0] ^ s0, CB);
          if (gtp(gt, s.p, PA, PB)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CA, CB);
          end
          if (gtp(gt, s.p, PC, PD)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CC, CD);
          end
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PA), ps(p, PA, PB), tv(p, PC), ps(p, PC, PD));
          r = emt(r, f, tv(p, PB), ps(p, PA, PB), ps(p, PC, PD), tv(p, PC));
          r = emt(r, f, tv(p, PA), ps(p, PA, PB), ps(p, PC, PD), tv(p, PD));
          r = emt(r, f, tv(p, PB), ps(p, PA, PB), tv(p, PD), ps(p, PC, PD));
        end
      end
      3'd3: begin
        if (c01 == 4'd0 || c02 == 4'd0 || c12 == 4'd0) begin
          // open strip: ends to A and B
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 4; i++)
              if (sl[k][i]) hits[i] = hits[i] + 2'd1;
          for (int i = 0; i < 4; i++) begin
            if (hits[i] == 2'd1) begin
              if (fi[2]) fi = 3'(i);
              else if (se2[2]) se2 = 3'(i);
            end
          end
          if (fi[2]) fi = 3'd0;
          if (se2[2]) se2 = 3'd0;
          rs = 4'd1 << fi[1:0];
          re = 4'd1 << se2[1:0];
          for (int k = 0; k < 3; k++) begin
            if (!fnd && (sl[k] & re) != 4'd0) begin
              rc  = sl[k] ^ re;
              fnd = 1'b1;
            end
          end
          re = trk(rs, CA, re);
          rc = trk(rs, CA, rc);
          if (rs != CA) s.par = ~s.par;
          s.p = pswap(s.p, rs, CA);
          rc = trk(re, CB, rc);
          if (re != CB) s.par = ~s.par;
          s.p = pswap(s.p, re, CB);
          if (rc != CC) s.par = ~s.par;
          s.p = pswap(s.p, rc, CC);
          if (gtp(gt, s.p, PA, PB)) begin
            s.p = pswap(s.p, CA, CB);
            s.p = pswap(s.p, CC, CD);
          end
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PB, PC), ps(p, PA, PD));
          if (gtp(gt, p, PA, PC)) begin
            r = emt(r, f, tv(p, PC), ps(p, PC, PD), ps(p, PA, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PA), tv(p, PC), ps(p, PA, PD), ps(p, PB, PC));
          end else begin
            r = emt(r, f, tv(p, PA), tv(p, PC), ps(p, PC, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PA), ps(p, PA, PD), ps(p, PB, PC), ps(p, PC, PD));
          end
          if (gtp(gt, p, PB, PD)) begin
            r = emt(r, f, tv(p, PD), ps(p, PB, PC), ps(p, PA, PD), ps(p, PC, PD));
            r = emt(r, f, tv(p, PD), tv(p, PB), ps(p, PA, PD), ps(p, PB, PC));
          end else begin
            r = emt(r, f, tv(p, PB), tv(p, PD), ps(p, PC, PD), ps(p, PA, PD));
            r = emt(r, f, tv(p, PB), ps(p, PB, PC), ps(p, PA, PD), ps(p, PC, PD));
          end
        end else if ((sl[2] & c01) != 4'd0) begin
          // fan round one corner
          if (c01 != CA) s.par = ~s.par;
          s.p = pswap(s.p, c01, CA);
          if (gtp(gt, s.p, PB, PC)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CB, CC);
          end
          if (gtp(gt, s.p, PC, PD)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CC, CD);
          end
          if (gtp(gt, s.p, PB, PC)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CB, CC);
          end
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PA), ps(p, PA, PB), ps(p, PA, PC), ps(p, PA, PD));
          r = emt(r, f, tv(p, PB), ps(p, PA, PB), ps(p, PA, PD), ps(p, PA, PC));
          r = emt(r, f, tv(p, PC), tv(p, PB), ps(p, PA, PD), ps(p, PA, PC));
          r = emt(r, f, tv(p, PB), tv(p, PC), ps(p, PA, PD), tv(p, PD));
        end else begin
          // triangle: free corner to D
          se = c01 | c02 | c12;
          if (!se[0]) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CA, CD);
          end else if (!se[1]) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CB, CD);
          end else if (!se[2]) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CC, CD);
          end
          if (gtp(gt, s.p, PA, PB)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CA, CB);
          end
          if (gtp(gt, s.p, PB, PC)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CB, CC);
          end
          if (gtp(gt, s.p, PA, PB)) begin
            s.par = ~s.par;
            s.p = pswap(s.p, CA, CB);
          end
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PD), ps(p, PA, PB), ps(p, PA, PC), ps(p, PB, PC));
          r = emt(r, f, tv(p, PD), ps(p, PA, PB), ps(p, PA, PC), tv(p, PA));
          r = emt(r, f, tv(p, PD), ps(p, PA, PB), ps(p, PB, PC), tv(p, PB));
          r = emt(r, f, tv(p, PD), ps(p, PA, PC), ps(p, PB, PC), tv(p, PC));
        end
      end
      3'd4: begin
        if ((nl[0] & nl[1]) != 4'd0) begin
          s = ter_touch(s, gt, nl[0], nl[1]);
          p = s.p;
          f = ~s.par;
          r = emt(r, f, tv(p, PD), ps(p, PA, PD), ps(p, PB, PD), ps(p, PC, PD));
          r = emt(r, f, ps(p, PB, PD), ps(p, PA, PD), ps(p, PB, PC), ps(p, PC, PD));
          if (gtp(gt, p, PB, PA) && gtp(gt, p, PC, PA)) begin
            r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PB, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PA), tv(p, PC), ps(p, PB, PC), ps(p, PC, PD));
            r = emt(r, f, tv(p, PA), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PD));
            r = emt(r, f, tv(p, PA), ps(p, PB, PC), ps(p, PA, PD), ps(p, PC, PD));
          end else if (gtp(gt, p, PA, PB) && gtp(gt, p, PC, PA)) begin
            r = emt(r, f, tv(p, PA), tv(p, PC), ps(p, PB, PC), ps(p, PC, PD));
            r = emt(r, f, tv(p, PA), ps(p, PB, PC), ps(p, PA, PD), ps(p, PC, PD));
            r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PA, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PB), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PD));
          end else begin
            r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PA, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PB), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PD));
            r = emt(r, f, tv(p, PC), tv(p, PA), ps(p, PA, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PC), ps(p, PB, PC), ps(p, PA, PD), ps(p, PC, PD));
          end
        end else begin
          s = ter_edge(s, gt, nl[0]);
          p = s.p;
          f = s.par;
          r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PB, PC), ps(p, PB, PD));
          r = emt(r, f, tv(p, PC), tv(p, PD), ps(p, PA, PD), ps(p, PB, PD));
          if (ltd(lt, p, PA, PD, PA, PC)) begin
            r = emt(r, f, tv(p, PA), ps(p, PA, PD), ps(p, PB, PC), ps(p, PA, PC));
            r = emt(r, f, tv(p, PA), ps(p, PA, PD), ps(p, PB, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PC), ps(p, PA, PD), ps(p, PA, PC), ps(p, PB, PC));
            r = emt(r, f, tv(p, PC), ps(p, PA, PD), ps(p, PB, PC), ps(p, PB, PD));
          end else begin
            r = emt(r, f, tv(p, PA), ps(p, PA, PD), ps(p, PB, PD), ps(p, PA, PC));
            r = emt(r, f, tv(p, PA), ps(p, PA, PC), ps(p, PB, PD), ps(p, PB, PC));
            r = emt(r, f, tv(p, PC), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PC));
            r = emt(r, f, tv(p, PC), ps(p, PB, PD), ps(p, PA, PD), ps(p, PA, PC));
          end
        end
      end
      3'd5: begin
        s = ter_edge(s, gt, nl[0]);
        p = s.p;
        f = s.par;
        r = emt(r, f, tv(p, PC), ps(p, PA, PC), ps(p, PB, PC), ps(p, PC, PD));
        r = emt(r, f, tv(p, PD), ps(p, PA, PD), ps(p, PC, PD), ps(p, PB, PD));
        r = emt(r, f, tv(p, PA), tv(p, PB), ps(p, PB, PC), ps(p, PB, PD));
        if (ltd(lt, p, PA, PC, PA, PD)) begin
          r = emt(r, f, tv(p, PA), ps(p, PA, PD), ps(p, PB, PD), ps(p, PA, PC));
          r = emt(r, f, tv(p, PA), ps(p, PA, PC), ps(p, PB, PD), ps(p, PB, PC));
          r = emt(r, f, ps(p, PC, PD), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PC));
          r = emt(r, f, ps(p, PC, PD), ps(p, PB, PD), ps(p, PA, PD), ps(p, PA, PC));
        end else begin
          r = emt(r, f, tv(p, PA), ps(p, PA, PC), ps(p, PA, PD), ps(p, PB, PC));
          r = emt(r, f, tv(p, PA), ps(p, PB, PD), ps(p, PB, PC), ps(p, PA, PD));
          r = emt(r, f, ps(p, PC, PD), ps(p, PB, PC), ps(p, PA, PD), ps(p, PA, PC));
          r = emt(r, f, ps(p, PC, PD), ps(p, PB, PD), ps(p, PA, PD), ps(p, PB, PC));
        end
      end
      default: begin
        // all six split: odd parity exchanges A and B, no output swap
        if (s.par) s.p = pswap(s.p, CA, CB);
        p = s.p;
        r = emt(r, 1'b0, tv(p, PA), ps(p, PA, PB), ps(p, PA, PC), ps(p, PA, PD));
        r = emt(r, 1'b0, tv(p, PB), ps(p, PA, PB), ps(p, PB, PD), ps(p, PB, PC));
        r = emt(r, 1'b0, tv(p, PC), ps(p, PA, PC), ps(p, PB, PC), ps(p, PC, PD));
        r = emt(r, 1'b0, tv(p, PD), ps(p, PA, PD), ps(p, PC, PD), ps(p, PB, PD));
        d1 = dg(eidx(p[PA], p[PB]));
        d2 = dg(eidx(p[PA], p[PC]));
        d3 = dg(eidx(p[PA], p[PD]));
        if (!lt[d2][d1] && !lt[d3][d1]) begin
          r = emt(r, 1'b0, ps(p, PA, PB), ps(p, PC, PD), ps(p, PA, PD), ps(p, PB, PD));
          r = emt(r, 1'b0, ps(p, PA, PB), ps(p, PC, PD), ps(p, PB, PD), ps(p, PB, PC));
          r = emt(r, 1'b0, ps(p, PA, PB), ps(p, PC, PD), ps(p, PB, PC), ps(p, PA, PC));
          r = emt(r, 1'b0, ps(p, PA, PB), ps(p, PC, PD), ps(p, PA, PC), ps(p, PA, PD));
        end else if (!lt[d1][d2] && !lt[d3][d2]) begin
          r = emt(r, 1'b0, ps(p, PA, PC), ps(p, PB, PD), ps(p, PC, PD), ps(p, PA, PD));
          r = emt(r, 1'b0, ps(p, PA, PC), ps(p, PB, PD), ps(p, PA, PD), ps(p, PA, PB));
          r = emt(r, 1'b0, ps(p, PA, PC), ps(p, PB, PD), ps(p, PA, PB), ps(p, PB, PC));
          r = emt(r, 1'b0, ps(p, PA, PC), ps(p, PB, PD), ps(p, PB, PC), ps(p, PC, PD));
        end else begin
          r = emt(r, 1'b0, ps(p, PA, PD), ps(p, PB, PC), ps(p, PB, PD), ps(p, PA, PB));
          r = emt(r, 1'b0, ps(p, PA, PD), ps(p, PB, PC), ps(p, PC, PD), ps(p, PB, PD));
          r = emt(r, 1'b0, ps(p, PA, PD), ps(p, PB, PC), ps(p, PA, PC), ps(p, PC, PD));
          r = emt(r, 1'b0, ps(p, PA, PD), ps(p, PB, PC), ps(p, PA, PB), ps(p, PA, PC));
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/tet_edge_split_refine_unit.sv */
`timescale 1ns / 1ps

// Channel | Dir | Handshake         | Beat
// in      | in  | valid_i / ready_o | corners a..d, edge splits ab..cd, diagonal lengths
// out     | out | valid_o / ready_i | one sub-tetrahedron, last_of_run_o on the final beat
//
// Stages: input reg, corner/length compares, corner sort, split-pattern decode into a
// run of symbols, then the run register that issues one beat a cycle into the output reg
// while that reg is free or ready_i is high. An item holds the run register until it has
// issued all of its sub-tetrahedra (1 to 8); that register sets the sustained rate.
// rst_ni clears the valid bits and the beat count. A stall freezes every stage holding a beat.
module tet_edge_split_refine_unit #(
  parameter int unsigned INDEX_BITS  = 20,
  parameter int unsigned LENGTH_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [INDEX_BITS-1:0]         vertex_a_i,
  input  logic [INDEX_BITS-1:0]         vertex_b_i,
  input  logic [INDEX_BITS-1:0]         vertex_c_i,
  input  logic [INDEX_BITS-1:0]         vertex_d_i,
  input  logic signed [INDEX_BITS:0]    split_ab_i,
  input  logic signed [INDEX_BITS:0]    split_ac_i,
  input  logic signed [INDEX_BITS:0]    split_ad_i,
  input  logic signed [INDEX_BITS:0]    split_bc_i,
  input  logic signed [INDEX_BITS:0]    split_bd_i,
  input  logic signed [INDEX_BITS:0]    split_cd_i,
  input  logic [3*LENGTH_BITS-1:0]      diagonal_lengths_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [INDEX_BITS-1:0]         out_first_o,
  output logic [INDEX_BITS-1:0]         out_second_o,
  output logic [INDEX_BITS-1:0]         out_third_o,
  output logic [INDEX_BITS-1:0]         out_fourth_o,
  output logic                          last_of_run_o
);
  import ter_pkg::*;

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned LB = LENGTH_BITS;

  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic                     adv1, adv2, adv3, adv4, out_adv, s4_last;

  logic [3:0][IB-1:0]       s1_vtx_q, s2_vtx_q, s3_vtx_q, s4_vtx_q;
  logic [5:0][IB:0]         s1_spl_q;
  logic [2:0][LB-1:0]       s1_len_q;
  logic [5:0][IB-1:0]       s2_idx_q, s3_idx_q, s4_idx_q;
  logic [5:0]               s2_sv_q, s3_sv_q;
  gt_t                      s2_gt_q, s3_gt_q, gt_d;
  lt_t                      s2_lt_q, s3_lt_q, lt_d;
  srt_t                     s3_srt_q;
  run_t                     s4_run_q;
  logic [2:0]               s4_cnt_q;

  logic [3:0][IB-1:0]       out_q, out_d;
  logic                     last_q;

  assign out_adv = !out_v_q || ready_i;
  assign s4_last = ({1'b0, s4_cnt_q} + 4'd1) == s4_run_q.n;
  assign adv4    = !s4_v_q || (out_adv && s4_last);
  assign adv3    = !s3_v_q || adv4;
  assign adv2    = !s2_v_q || adv3;
  assign adv1    = !s1_v_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        gt_d[i][j] = s1_vtx_q[i] > s1_vtx_q[j];
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++)
        lt_d[x][y] = s1_len_q[x] < s1_len_q[y];
  end

  // symbol to value: corner index or inserted point index
  always_comb begin
    sym_t sy;
    for (int j = 0; j < 4; j++) begin
      sy = s4_run_q.sym[s4_cnt_q][j];
      if (sy < SymSplit) out_d[j] = s4_vtx_q[sy[1:0]];
      else if (sy <= SymLast) out_d[j] = s4_idx_q[3'(sy - SymSplit)];
      else out_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      s4_cnt_q <= '0;
    end else begin
      if (adv1) s1_v_q <= valid_i;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) begin
        s4_v_q   <= s3_v_q;
        s4_cnt_q <= '0;
      end else if (out_adv) begin
        s4_cnt_q <= s4_cnt_q + 3'd1;
      end
      if (out_adv) out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_vtx_q <= {vertex_d_i, vertex_c_i, vertex_b_i, vertex_a_i};
      s1_spl_q <= {split_cd_i, split_bd_i, split_bc_i, split_ad_i, split_ac_i, split_ab_i};
      s1_len_q <= diagonal_lengths_i;
    end
    if (adv2) begin
      s2_vtx_q <= s1_vtx_q;
      for (int i = 0; i < 6; i++) begin
        s2_idx_q[i] <= s1_spl_q[i][IB-1:0];
        s2_sv_q[i]  <= !s1_spl_q[i][IB];
      end
      s2_gt_q <= gt_d;
      s2_lt_q <= lt_d;
    end
    if (adv3) begin
      s3_vtx_q <= s2_vtx_q;
      s3_idx_q <= s2_idx_q;
      s3_sv_q  <= s2_sv_q;
      s3_gt_q  <= s2_gt_q;
      s3_lt_q  <= s2_lt_q;
      s3_srt_q <= ter_sort(s2_gt_q);
    end
    if (adv4) begin
      s4_vtx_q <= s3_vtx_q;
      s4_idx_q <= s3_idx_q;
      s4_run_q <= ter_build(s3_srt_q, s3_sv_q, s3_gt_q, s3_lt_q);
    end
    if (out_adv && s4_v_q) begin
      out_q  <= out_d;
      last_q <= s4_last;
    end
  end

  assign valid_o       = out_v_q;
  assign out_first_o   = out_q[0];
  assign out_second_o  = out_q[1];
  assign out_third_o   = out_q[2];
  assign out_fourth_o  = out_q[3];
  assign last_of_run_o = last_q;

endmodule
